### rtl/mpa_pkg.sv
package mpa_pkg;

  localparam int DEF_MAX_BOARD   = 256;
  localparam int DEF_MAX_POOL    = 8;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int BOARD_CFG_W = 9;
  localparam int POOL_CFG_W  = 4;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 1'd1;

  localparam logic [BOARD_CFG_W-1:0] BOARD_RESET = 9'd32;
  localparam logic [POOL_CFG_W-1:0]  POOL_RESET  = 4'd2;

  localparam int SEL_W     = 6;
  localparam int OUT_POS_W = 8;

  typedef struct packed {
    logic in_span;
    logic first;
    logic last;
    logic plane_last;
  } pos_flags_t;

endpackage

### rtl/mpa_in_if.sv
interface mpa_in_if import mpa_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

### rtl/mpa_out_if.sv
interface mpa_out_if import mpa_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] max_value;
  logic [SEL_W-1:0]              selector;
  logic [OUT_POS_W-1:0]          out_row;
  logic [OUT_POS_W-1:0]          out_col;
  logic                          last_of_plane;

  modport source (output valid, output max_value, output selector, output out_row,
                  output out_col, output last_of_plane, input ready);
  modport sink (input valid, input max_value, input selector, input out_row,
                input out_col, input last_of_plane, output ready);
endinterface

### rtl/mpa_pos.sv
module mpa_pos import mpa_pkg::*; #(
  parameter int MAX_BOARD = DEF_MAX_BOARD,
  parameter int MAX_POOL  = DEF_MAX_POOL,
  localparam int PW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  output pos_flags_t            flags,
  output logic [PW-1:0]         addr,
  output logic [SEL_W-1:0]      sel,
  output logic [OUT_POS_W-1:0]  orow,
  output logic [OUT_POS_W-1:0]  ocol
);

  localparam int QW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int BW = $clog2(MAX_BOARD + 1);
  localparam int KW = $clog2(MAX_POOL + 1);
  localparam int SW = ((BW > KW) ? BW : KW) + 2;
  localparam int CW = (BOARD_CFG_W > SW) ? BOARD_CFG_W : SW;
  localparam int MW = QW + KW + 1;

  function automatic logic [BW-1:0] sat_board(input logic [BOARD_CFG_W-1:0] raw);
    logic [CW-1:0] x;
    x = CW'(raw);
    if (x == '0) return BW'(1);
    if (x > CW'(MAX_BOARD)) return BW'(MAX_BOARD);
    return BW'(x);
  endfunction

  function automatic logic [KW-1:0] sat_pool(input logic [POOL_CFG_W-1:0] raw);
    logic [CW-1:0] x;
    x = CW'(raw);
    if (x == '0) return KW'(1);
    if (x > CW'(MAX_POOL)) return KW'(MAX_POOL);
    return KW'(x);
  endfunction

  logic [BW-1:0] board_r;
  logic [KW-1:0] pool_r;
  logic [PW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [PW-1:0] wcol_r, wcol_nxt, wrow_r, wrow_nxt;
  logic [PW-1:0] ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [QW-1:0] ciw_r, ciw_nxt, riw_r, riw_nxt;
  logic [SW-1:0] b_ext, p_ext;
  logic [MW-1:0] sel_full;

  assign b_ext = SW'(board_r);
  assign p_ext = SW'(pool_r);

  assign flags.in_span    = (SW'(wcol_r) + p_ext <= b_ext) && (SW'(wrow_r) + p_ext <= b_ext);
  assign flags.first      = (ciw_r == '0) && (riw_r == '0);
  assign flags.last       = (SW'(ciw_r) + SW'(1) == p_ext) && (SW'(riw_r) + SW'(1) == p_ext);
  assign flags.plane_last = (SW'(wcol_r) + (p_ext << 1) > b_ext)
                         && (SW'(wrow_r) + (p_ext << 1) > b_ext);

  assign sel_full = MW'(riw_r) * MW'(pool_r) + MW'(ciw_r);
  assign sel      = SEL_W'(sel_full);
  assign addr     = ocol_r;
  assign orow     = OUT_POS_W'(orow_r);
  assign ocol     = OUT_POS_W'(ocol_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    wcol_nxt = wcol_r;
    wrow_nxt = wrow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    ciw_nxt  = ciw_r;
    riw_nxt  = riw_r;
    if (SW'(col_r) + SW'(1) >= b_ext) begin
      col_nxt  = '0;
      ciw_nxt  = '0;
      ocol_nxt = '0;
      wcol_nxt = '0;
      if (SW'(row_r) + SW'(1) >= b_ext) begin
        row_nxt  = '0;
        riw_nxt  = '0;
        orow_nxt = '0;
        wrow_nxt = '0;
      end else begin
        row_nxt = row_r + PW'(1);
        if (SW'(riw_r) + SW'(1) >= p_ext) begin
          riw_nxt  = '0;
          orow_nxt = orow_r + PW'(1);
          wrow_nxt = row_r + PW'(1);
        end else begin
          riw_nxt = riw_r + QW'(1);
        end
      end
    end else begin
      col_nxt = col_r + PW'(1);
      if (SW'(ciw_r) + SW'(1) >= p_ext) begin
        ciw_nxt  = '0;
        ocol_nxt = ocol_r + PW'(1);
        wcol_nxt = col_r + PW'(1);
      end else begin
        ciw_nxt = ciw_r + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_r <= sat_board(BOARD_RESET);
      pool_r  <= sat_pool(POOL_RESET);
    end else if (cfg_we) begin
      if (cfg_index == REG_BOARD_SIZE) begin
        board_r <= sat_board(BOARD_CFG_W'(cfg_data));
      end
      if (cfg_index == REG_POOL_SIZE) begin
        pool_r <= sat_pool(POOL_CFG_W'(cfg_data));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && (cfg_index == REG_BOARD_SIZE || cfg_index == REG_POOL_SIZE))) begin
      col_r  <= '0;
      row_r  <= '0;
      wcol_r <= '0;
      wrow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      ciw_r  <= '0;
      riw_r  <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      wcol_r <= wcol_nxt;
      wrow_r <= wrow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      ciw_r  <= ciw_nxt;
      riw_r  <= riw_nxt;
    end
  end

endmodule

### rtl/max_pool_with_argmax_unit.sv
// A window's result passes through the stage-1 registers and then the output register to out_ch.
// Throughput: one word per cycle unless in_ch stalls; the row store has one read and at most one write per word,
// with the write of the word ahead forwarded to the read of the next.
// in_ch stalls only while a result waits on a full output register that is not taken.
// Reset (rst_n, synchronous, active low): board 32, pool 2, position at plane start,
// pipeline empty. The row store is not cleared; a window's first word writes its entry.
module max_pool_with_argmax_unit import mpa_pkg::*; #(
  parameter int MAX_BOARD   = DEF_MAX_BOARD,
  parameter int MAX_POOL    = DEF_MAX_POOL,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpa_in_if.sink                in_ch,
  mpa_out_if.source             out_ch
);

  localparam int PW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int EW = VALUE_WIDTH + SEL_W;

  logic [EW-1:0] mem [MAX_BOARD];

  pos_flags_t            flags, s1_flags_r;
  logic [PW-1:0]         addr, s1_addr_r;
  logic [SEL_W-1:0]      sel, s1_sel_r;
  logic [OUT_POS_W-1:0]  orow, ocol, s1_orow_r, s1_ocol_r;
  logic                  acc, advance;
  logic                  s1_valid_r;
  logic signed [VALUE_WIDTH-1:0] s1_val_r;
  logic [EW-1:0]         rd_r, fwd_r, old_entry, new_entry;
  logic                  fwd_hit_r;
  logic signed [VALUE_WIDTH-1:0] old_max;
  logic                  upd, s1_wr, s1_emit;
  logic                  out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_max_r;
  logic [SEL_W-1:0]      out_sel_r;
  logic [OUT_POS_W-1:0]  out_row_r, out_col_r;
  logic                  out_last_r;

  mpa_pos #(
    .MAX_BOARD (MAX_BOARD),
    .MAX_POOL  (MAX_POOL)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .flags     (flags),
    .addr      (addr),
    .sel       (sel),
    .orow      (orow),
    .ocol      (ocol)
  );

  assign old_entry = fwd_hit_r ? fwd_r : rd_r;
  assign old_max   = old_entry[VALUE_WIDTH-1:0];
  assign upd       = s1_flags_r.first || (s1_val_r > old_max);
  assign new_entry = upd ? {s1_sel_r, s1_val_r} : old_entry;
  assign s1_emit   = s1_valid_r && s1_flags_r.in_span && s1_flags_r.last;
  assign advance   = !(s1_emit && out_valid_r && !out_ch.ready);
  assign s1_wr     = advance && s1_valid_r && s1_flags_r.in_span && upd;
  assign acc       = in_ch.valid && advance;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_addr_r] <= new_entry;
    end
    if (advance) begin
      rd_r      <= mem[addr];
      fwd_r     <= new_entry;
      fwd_hit_r <= s1_wr && (s1_addr_r == addr);
      s1_flags_r <= flags;
      s1_addr_r  <= addr;
      s1_sel_r   <= sel;
      s1_val_r   <= in_ch.pixel_value;
      s1_orow_r  <= orow;
      s1_ocol_r  <= ocol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      out_max_r  <= new_entry[VALUE_WIDTH-1:0];
      out_sel_r  <= new_entry[EW-1:VALUE_WIDTH];
      out_row_r  <= s1_orow_r;
      out_col_r  <= s1_ocol_r;
      out_last_r <= s1_flags_r.plane_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.max_value     = out_max_r;
  assign out_ch.selector      = out_sel_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.last_of_plane = out_last_r;

endmodule

### dv/max_pool_with_argmax_checker.sv
module max_pool_with_argmax_checker import mpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpa_in_if                     in_ch,
  mpa_out_if                    out_ch,
  input  logic                  end_check,
  output int                    pending,
  output int                    errors
);

  localparam int STORE_DEPTH = DEF_MAX_BOARD;

  typedef struct packed {
    logic signed [DEF_VALUE_WIDTH-1:0] max_value;
    logic [SEL_W-1:0]                  selector;
    logic [OUT_POS_W-1:0]              row;
    logic [OUT_POS_W-1:0]              col;
    logic                              plane_last;
  } pool_result_t;

  logic [BOARD_CFG_W-1:0]            board_reg;
  logic [POOL_CFG_W-1:0]             pool_reg;
  int unsigned                       pix_row, pix_col, win_row, win_col, col_slot;
  logic signed [DEF_VALUE_WIDTH-1:0] run_max [STORE_DEPTH];
  logic [SEL_W-1:0]                  run_sel [STORE_DEPTH];
  pool_result_t                      window_results[$];
  int                                fail_total = 0;
  bit                                leftover_done = 1'b0;

  function automatic int unsigned board_side();
    if (board_reg == 0) return 1;
    if (board_reg > STORE_DEPTH) return STORE_DEPTH;
    return board_reg;
  endfunction

  function automatic int unsigned pool_side();
    if (pool_reg == 0) return 1;
    if (pool_reg > DEF_MAX_POOL) return DEF_MAX_POOL;
    return pool_reg;
  endfunction

  function automatic void plane_restart();
    pix_row  = 0;
    pix_col  = 0;
    win_row  = 0;
    win_col  = 0;
    col_slot = 0;
  endfunction

  function automatic string fmt_result(pool_result_t r);
    return $sformatf("max %0d sel %0d row %0d col %0d last %0b",
                     r.max_value, r.selector, r.row, r.col, r.plane_last);
  endfunction

  function automatic void note_error(string msg);
    fail_total++;
    if (fail_total <= 10) $display("ERROR: %s", msg);
  endfunction

  // one pixel word: update the column's running max, emit when the window closes
  function automatic void pool_pixel(logic signed [DEF_VALUE_WIDTH-1:0] px);
    int unsigned  b, p, side_out, span, sel;
    pool_result_t r;
    b        = board_side();
    p        = pool_side();
    side_out = b / p;
    span     = side_out * p;
    if (pix_col < span && pix_row < span && col_slot < STORE_DEPTH) begin
      sel = win_row * p + win_col;
      if ((win_row == 0 && win_col == 0) || px > run_max[col_slot]) begin
        run_max[col_slot] = px;
        run_sel[col_slot] = sel[SEL_W-1:0];
      end
      if (win_row == p - 1 && win_col == p - 1) begin
        r.max_value  = run_max[col_slot];
        r.selector   = run_sel[col_slot];
        r.row        = OUT_POS_W'(pix_row / p);
        r.col        = OUT_POS_W'(col_slot);
        r.plane_last = (pix_row / p == side_out - 1) && (col_slot == side_out - 1);
        window_results.push_back(r);
      end
    end
    if (pix_col + 1 >= b) begin
      pix_col  = 0;
      win_col  = 0;
      col_slot = 0;
      if (pix_row + 1 >= b) begin
        pix_row = 0;
        win_row = 0;
      end else begin
        pix_row++;
        win_row = (win_row + 1 >= p) ? 0 : win_row + 1;
      end
    end else begin
      pix_col++;
      if (win_col + 1 >= p) begin
        win_col = 0;
        col_slot++;
      end else begin
        win_col++;
      end
    end
  endfunction

  function automatic void check_result(pool_result_t got);
    pool_result_t want;
    if (window_results.size() == 0) begin
      note_error({"result with none expected: ", fmt_result(got)});
      return;
    end
    want = window_results.pop_front();
    if (got !== want)
      note_error({"expected ", fmt_result(want), ", got ", fmt_result(got)});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      board_reg = BOARD_RESET;
      pool_reg  = POOL_RESET;
      plane_restart();
      window_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BOARD_SIZE) begin
          board_reg = cfg_data[BOARD_CFG_W-1:0];
          plane_restart();
        end else if (cfg_index == REG_POOL_SIZE) begin
          pool_reg = cfg_data[POOL_CFG_W-1:0];
          plane_restart();
        end
      end
      if (out_ch.valid && out_ch.ready)
        check_result({out_ch.max_value, out_ch.selector, out_ch.out_row,
                      out_ch.out_col, out_ch.last_of_plane});
      if (in_ch.valid && in_ch.ready) pool_pixel(in_ch.pixel_value);
      if (end_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (window_results.size() != 0) begin
          $display("ERROR: %0d expected results never arrived", window_results.size());
          fail_total += window_results.size();
        end
      end
    end
    pending <= window_results.size();
    errors  <= fail_total;
  end

endmodule

### dv/max_pool_with_argmax_unit_test.sv
module max_pool_with_argmax_unit_test;
  import mpa_pkg::*;

  typedef logic signed [DEF_VALUE_WIDTH-1:0] word_t;
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam word_t MOST_NEG       = 16'sh8000;
  localparam word_t MOST_POS       = 16'sh7FFF;
  localparam int    SETTLE_CYCLES  = 4;
  localparam int    HOLD_CYCLES    = 100;
  localparam int    WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  end_check;
  logic                  hold_req;
  int                    pending;
  int                    errors;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    words_in = 0;
  int                    results_out = 0;
  int                    settings_used;

  mpa_in_if  in_ch ();
  mpa_out_if out_ch ();

  max_pool_with_argmax_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  max_pool_with_argmax_checker pool_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .end_check (end_check),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) words_in++;
      if (out_ch.valid && out_ch.ready) results_out++;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 48;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 48;
      end
      default: begin
        send_idle_pct  = 34;
        recv_stall_pct = 34;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pool register upper data bits are don't-care; fill them with noise
  task automatic configure(input logic [BOARD_CFG_W-1:0] board, input logic [POOL_CFG_W-1:0] pool);
    drain_results();
    write_reg(REG_BOARD_SIZE, board);
    write_reg(REG_POOL_SIZE, {(CFG_DATA_W-POOL_CFG_W)'($urandom_range(31)), pool});
    settings_used++;
  endtask

  task automatic send_pixel(input word_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // small values give frequent ties for the first-max rule
  function automatic word_t pick_value();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2, 3, 4: return word_t'($urandom_range(6)) - word_t'(3);
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic run_words(input logic [BOARD_CFG_W-1:0] board,
                           input logic [POOL_CFG_W-1:0] pool, input word_t words[$]);
    set_idle(IDLE_NONE);
    configure(board, pool);
    foreach (words[i]) send_pixel(words[i]);
  endtask

  task automatic run_phase(input logic [BOARD_CFG_W-1:0] board, input logic [POOL_CFG_W-1:0] pool,
                           input int count, input idle_mode_t mode, input bit squeeze);
    int i;
    set_idle(mode);
    configure(board, pool);
    for (i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      if (squeeze && i == 8) hold_req <= 1'b1;
      send_pixel(pick_value());
    end
  endtask

  initial begin
    word_t words[$];
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_BOARD_SIZE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.pixel_value <= '0;
    end_check         <= 1'b0;
    hold_req          <= 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    settings_used     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ties at the extremes, first-max rule, selectors 0, 1 and 3 of a 2x2 window
    words = '{MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
              MOST_NEG, MOST_POS, MOST_POS, 16'sd0,
              16'sd1, 16'sd2, -16'sd1, MOST_POS};
    run_words(9'd2, 4'd2, words);
    // zero sizes act as one
    words = '{MOST_POS, MOST_NEG};
    run_words(9'd0, 4'd0, words);
    // window larger than plane: nothing comes out
    words = '{16'sd7, -16'sd7, 16'sd0};
    run_words(9'd3, 4'd5, words);
    // edge pixels carry the largest values but must be ignored
    words = '{-16'sd5, -16'sd5, 16'sd100, -16'sd5, -16'sd4, 16'sd100,
              16'sd100, 16'sd100, 16'sd100};
    run_words(9'd3, 4'd2, words);

    run_phase(9'd4,   4'd2,  96,  IDLE_NONE, 1'b0);
    run_phase(9'd6,   4'd3,  108, IDLE_SEND, 1'b0);
    run_phase(9'd7,   4'd2,  98,  IDLE_RECV, 1'b0);
    run_phase(9'd8,   4'd15, 128, IDLE_BOTH, 1'b0);
    run_phase(9'd9,   4'd4,  81,  IDLE_NONE, 1'b0);
    run_phase(9'd1,   4'd1,  40,  IDLE_SEND, 1'b0);
    run_phase(9'd511, 4'd1,  200, IDLE_RECV, 1'b1);
    run_phase(9'd5,   4'd0,  50,  IDLE_BOTH, 1'b0);
    run_phase(9'd2,   4'd8,  20,  IDLE_NONE, 1'b0);
    run_phase(9'd16,  4'd8,  256, IDLE_SEND, 1'b0);
    run_phase(9'd10,  4'd3,  100, IDLE_RECV, 1'b0);
    run_phase(9'd3,   4'd1,  45,  IDLE_BOTH, 1'b0);
    run_phase(9'd12,  4'd6,  72,  IDLE_NONE, 1'b0);
    run_phase(9'd300, 4'd2,  520, IDLE_BOTH, 1'b0);

    drain_results();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Run covered %0d pixel words and %0d pooled results over %0d board/pool settings,",
             words_in, results_out, settings_used);
    $display("incl. zero and saturating sizes, edge pixels, ties and long output back-pressure.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mpa_pkg.sv
rtl/mpa_in_if.sv
rtl/mpa_out_if.sv
rtl/mpa_pos.sv
rtl/max_pool_with_argmax_unit.sv
dv/max_pool_with_argmax_checker.sv
dv/max_pool_with_argmax_unit_test.sv
